// ----- rtl/dmt_pkg.sv -----
package dmt_pkg;

   // Field and register widths
   localparam int SpeedBits    = 24;
   localparam int CountBits    = 16;
   localparam int DebounceBits = 20;
   localparam int CutoffBits   = 24;
   localparam int CsrIndexBits = 4;
   localparam int CsrDataBits  = 32;

   // Speed averaging ring
   localparam int RingDepth   = 4;
   localparam int RingIdxBits = $clog2(RingDepth);
   localparam int RingSumBits = SpeedBits + RingIdxBits;

   // Speed scale factors: one minute in microseconds over four tacho level changes per turn, and twice that
   localparam int MulConstBits = 25;
   localparam logic [SpeedBits-1:0]    LowModeNumerator = 24'd15000000;
   localparam logic [MulConstBits-1:0] HighModeScale    = 25'd30000000;

   // Dividend covers the pulse count times the high-mode scale
   localparam int DvdBits = CountBits + MulConstBits;

   // Parameter defaults
   localparam int TimerBitsDefault  = 32;
   localparam int QueueDepthDefault = 4;

   // Register reset values
   localparam logic [DebounceBits-1:0] DebounceReset = 20'd100;
   localparam logic [CutoffBits-1:0]   CutoffReset   = 24'd3000;
   localparam logic [31:0]             StaleReset    = 32'd1000000;
   localparam logic [31:0]             PeriodReset   = 32'd100000;

   // Register indexes
   localparam logic [CsrIndexBits-1:0] CsrDebounce = 4'd0;
   localparam logic [CsrIndexBits-1:0] CsrCutoff   = 4'd1;
   localparam logic [CsrIndexBits-1:0] CsrStale    = 4'd2;
   localparam logic [CsrIndexBits-1:0] CsrPeriod   = 4'd3;

   // Classified tick handed from front to back
   typedef struct packed {
      logic rise;
      logic fall;
   } tick_type;

   // Configuration register set
   typedef struct packed {
      logic [DebounceBits-1:0] debounce_us;
      logic [CutoffBits-1:0]   mode_cutoff;
      logic [31:0]             stale_timeout_us;
      logic [31:0]             update_period_us;
   } cfg_type;

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/dual_mode_tachometer_core.sv -----
// Dual-mode tachometer: one request per microsecond tick carries the sampled
// tacho level, and each request yields one response with the speed estimate and
// the active mode. Requests enter a QUEUE_DEPTH-entry queue behind an edge
// classifier and are processed in order. A tick that needs no division is
// answered from the step state once the output is free. A tick that ends a
// debounced pulse in pulse-width mode, or closes a counting window in
// pulse-count mode, goes through the shared radix-2 divider (one quotient bit
// per clock over 41 bits), and in pulse-count mode through the ring average as
// well; requests keep queuing meanwhile. There is no clearing pass after reset.
// Configuration registers: 0 debounce, 1 cutoff, 2 stale timeout, 3 window
// length; other indexes are ignored. csr_ready is always high.
module dual_mode_tachometer_core #(
   parameter int TIMER_BITS  = dmt_pkg::TimerBitsDefault,
   parameter int QUEUE_DEPTH = dmt_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_tacho_level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dmt_pkg::SpeedBits-1:0]     rsp_speed_value,
   output logic                              rsp_high_mode,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dmt_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [dmt_pkg::CsrDataBits-1:0]   csr_wdata
);

   dmt_pkg::cfg_type  cfg_ff;
   dmt_pkg::cfg_type  cfg_in;
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;
   dmt_pkg::tick_type push_tick;
   dmt_pkg::tick_type pop_tick;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dmt_pkg::CsrDebounce: begin
               cfg_in.debounce_us = csr_wdata[dmt_pkg::DebounceBits-1:0];
            end
            dmt_pkg::CsrCutoff: begin
               cfg_in.mode_cutoff = csr_wdata[dmt_pkg::CutoffBits-1:0];
            end
            dmt_pkg::CsrStale: begin
               cfg_in.stale_timeout_us = csr_wdata[31:0];
            end
            dmt_pkg::CsrPeriod: begin
               cfg_in.update_period_us = csr_wdata[31:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_us      <= dmt_pkg::DebounceReset;
         cfg_ff.mode_cutoff      <= dmt_pkg::CutoffReset;
         cfg_ff.stale_timeout_us <= dmt_pkg::StaleReset;
         cfg_ff.update_period_us <= dmt_pkg::PeriodReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify edges on accepted requests
   dmt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tacho_level (req_tacho_level),
      .queue_full      (q_full),
      .push            (q_push),
      .push_tick       (push_tick)
   );

   // Decouple classification from execution
   dmt_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_tick (push_tick),
      .pop       (q_pop),
      .pop_tick  (pop_tick),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Timers, division, ring average, mode and response
   dmt_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_tick          (pop_tick),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_speed_value (rsp_speed_value),
      .rsp_high_mode   (rsp_high_mode)
   );

   // Pulse-count mode is only entered with a speed above the cutoff, so never zero
   a_high_mode_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_high_mode) |-> (rsp_speed_value != '0))
      else $error("high mode response with zero speed");

   // Reset leaves an empty queue and no pending response
   a_reset_clean: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!rsp_valid && !req_stall))
      else $error("response or stall present right after reset");

endmodule

// ----- rtl/dmt_front.sv -----
module dmt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_tacho_level,
   input  logic              queue_full,
   output logic              push,
   output dmt_pkg::tick_type push_tick
);

   logic prev_level_ff;
   logic prev_level_in;
   logic accept;

   // Stall while the queue has no room
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // Classify the sampled level against the previous one
   assign push_tick.rise = req_tacho_level && !prev_level_ff;
   assign push_tick.fall = !req_tacho_level && prev_level_ff;

   // Hold the level of the last accepted request
   assign prev_level_in = accept ? req_tacho_level : prev_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
      end else begin
         prev_level_ff <= prev_level_in;
      end
   end

endmodule

// ----- rtl/dmt_fifo.sv -----
module dmt_fifo #(
   parameter int DEPTH = dmt_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dmt_pkg::tick_type push_tick,
   input  logic              pop,
   output dmt_pkg::tick_type pop_tick,
   output logic              full,
   output logic              empty
);

   localparam int PtrBits   = $clog2(DEPTH);
   localparam int CountBits = $clog2(DEPTH + 1);
   localparam logic [PtrBits-1:0]   LastPtr = PtrBits'(DEPTH - 1);
   localparam logic [CountBits-1:0] FullCnt = CountBits'(DEPTH);

   dmt_pkg::tick_type     entry_ff [DEPTH];
   logic [PtrBits-1:0]    wr_ptr_ff;
   logic [PtrBits-1:0]    wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff;
   logic [PtrBits-1:0]    rd_ptr_in;
   logic [CountBits-1:0]  count_ff;
   logic [CountBits-1:0]  count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_tick = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap, track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed tick
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_tick;
      end
   end

endmodule

// ----- rtl/dmt_div.sv -----
module dmt_div #(
   parameter int DVD_BITS = dmt_pkg::DvdBits,
   parameter int DVS_BITS = dmt_pkg::TimerBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DVD_BITS-1:0]         dividend,
   input  logic [DVS_BITS-1:0]         divisor,
   output dmt_pkg::div_status_type     status,
   output logic [DVD_BITS-1:0]         quotient
);

   localparam int StepBits = $clog2(DVD_BITS);
   localparam logic [StepBits-1:0] LastStep = StepBits'(DVD_BITS - 1);

   logic                busy_ff;
   logic                busy_in;
   logic                done_ff;
   logic                done_in;
   logic [StepBits-1:0] step_ff;
   logic [StepBits-1:0] step_in;
   logic [DVS_BITS-1:0] rem_ff;
   logic [DVS_BITS-1:0] rem_in;
   logic [DVD_BITS-1:0] quo_ff;
   logic [DVD_BITS-1:0] quo_in;
   logic [DVS_BITS-1:0] dvs_ff;
   logic [DVS_BITS-1:0] dvs_in;
   logic [DVS_BITS:0]   trial;
   logic [DVS_BITS:0]   diff;
   logic                fits;

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[DVD_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
         quo_in  = {quo_ff[DVD_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ----- rtl/dmt_back.sv -----
module dmt_back #(
   parameter int TIMER_BITS = dmt_pkg::TimerBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dmt_pkg::cfg_type                cfg,
   input  logic                            q_empty,
   input  dmt_pkg::tick_type               q_tick,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dmt_pkg::SpeedBits-1:0]   rsp_speed_value,
   output logic                            rsp_high_mode
);

   localparam int SpeedBits = dmt_pkg::SpeedBits;
   localparam int CountBits = dmt_pkg::CountBits;
   localparam int DvdBits   = dmt_pkg::DvdBits;
   localparam logic [31:0] TimerMax32 = 32'((64'd1 << TIMER_BITS) - 64'd1);

   typedef enum logic [4:0] {
      ST_STEP = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_EMIT = 5'b10000
   } back_state_type;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
      return (&t) ? t : t + 1'b1;
   endfunction

   back_state_type                  state_ff;
   back_state_type                  state_in;
   logic                            mode_ff;
   logic                            mode_in;
   logic [TIMER_BITS-1:0]           width_ff;
   logic [TIMER_BITS-1:0]           width_in;
   logic [TIMER_BITS-1:0]           stale_ff;
   logic [TIMER_BITS-1:0]           stale_in;
   logic [TIMER_BITS-1:0]           window_ff;
   logic [TIMER_BITS-1:0]           window_in;
   logic [CountBits-1:0]            count_ff;
   logic [CountBits-1:0]            count_in;
   logic [SpeedBits-1:0]            ring_ff [dmt_pkg::RingDepth];
   logic [SpeedBits-1:0]            ring_in [dmt_pkg::RingDepth];
   logic [dmt_pkg::RingIdxBits-1:0] ridx_ff;
   logic [dmt_pkg::RingIdxBits-1:0] ridx_in;
   logic [SpeedBits-1:0]            speed_ff;
   logic [SpeedBits-1:0]            speed_in;
   logic [CountBits-1:0]            cnt_lat_ff;
   logic [CountBits-1:0]            cnt_lat_in;
   logic [TIMER_BITS-1:0]           dvs_ff;
   logic [TIMER_BITS-1:0]           dvs_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [SpeedBits-1:0]            rsp_speed_ff;
   logic [SpeedBits-1:0]            rsp_speed_in;
   logic                            rsp_mode_ff;
   logic                            rsp_mode_in;

   logic [TIMER_BITS-1:0]           w_inc;
   logic [TIMER_BITS-1:0]           s_inc;
   logic [TIMER_BITS-1:0]           win_inc;
   logic [TIMER_BITS-1:0]           period;
   logic                            width_ok;
   logic [TIMER_BITS-1:0]           t_w;
   logic [TIMER_BITS-1:0]           t_s;
   logic [TIMER_BITS-1:0]           t_win;
   logic [CountBits-1:0]            t_cnt;
   logic                            t_low_div;
   logic                            t_high_div;

   logic                            step_src;
   logic                            e_mode;
   logic [TIMER_BITS-1:0]           e_s;
   logic [TIMER_BITS-1:0]           e_win;
   logic [CountBits-1:0]            e_cnt;
   logic [SpeedBits-1:0]            e_out;

   logic                            out_free;
   logic                            commit;
   logic                            div_start;
   logic [DvdBits-1:0]              div_dividend;
   logic [DvdBits-1:0]              div_quo;
   dmt_pkg::div_status_type         div_stat;
   logic [SpeedBits-1:0]            q_sat;
   logic [dmt_pkg::RingSumBits-1:0] ring_sum;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_value = rsp_speed_ff;
   assign rsp_high_mode   = rsp_mode_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // Clamp the window length into 1 .. timer maximum
   always_comb begin
      if (cfg.update_period_us == '0) begin
         period = TIMER_BITS'(1);
      end else if (cfg.update_period_us > TimerMax32) begin
         period = '1;
      end else begin
         period = cfg.update_period_us[TIMER_BITS-1:0];
      end
   end

   // Apply one tick to the timers and the pulse counter
   always_comb begin
      w_inc      = sat_inc(width_ff);
      s_inc      = sat_inc(stale_ff);
      win_inc    = sat_inc(window_ff);
      width_ok   = (32'(w_inc) > 32'(cfg.debounce_us));
      t_w        = w_inc;
      t_s        = s_inc;
      t_win      = window_ff;
      t_cnt      = count_ff;
      t_low_div  = 1'b0;
      t_high_div = 1'b0;
      if (!mode_ff) begin
         if (q_tick.rise) begin
            t_w = '0;
         end
         if (q_tick.fall && width_ok) begin
            t_low_div = 1'b1;
            t_s       = '0;
         end
      end else begin
         if (q_tick.fall) begin
            if (width_ok && (count_ff != '1)) begin
               t_cnt = count_ff + 1'b1;
            end
            t_w = '0;
         end
         t_win = win_inc;
         if (win_inc >= period) begin
            t_high_div = 1'b1;
            t_win      = '0;
         end
      end
   end

   // Re-evaluate the mode against the cutoff and form the reported speed
   always_comb begin
      step_src = (state_ff == ST_STEP);
      e_s      = step_src ? t_s : stale_ff;
      e_win    = step_src ? t_win : window_ff;
      e_cnt    = step_src ? t_cnt : count_ff;
      if (speed_ff > cfg.mode_cutoff) begin
         e_mode = 1'b1;
         if (!mode_ff) begin
            e_win = '0;
            e_cnt = '0;
         end
         e_out = speed_ff;
      end else begin
         e_mode = 1'b0;
         if (mode_ff) begin
            e_s = '0;
         end
         e_out = (32'(e_s) > cfg.stale_timeout_us) ? '0 : speed_ff;
      end
   end

   // Saturate the divider result and average the ring
   always_comb begin
      q_sat    = (|div_quo[DvdBits-1:SpeedBits]) ? '1 : div_quo[SpeedBits-1:0];
      ring_sum = '0;
      for (int i = 0; i < dmt_pkg::RingDepth; i++) begin
         ring_sum = ring_sum + dmt_pkg::RingSumBits'(ring_ff[i]);
      end
   end

   // Scale the latched pulse count, or pick the pulse-width numerator
   assign div_dividend = mode_ff ? DvdBits'(cnt_lat_ff) * DvdBits'(dmt_pkg::HighModeScale)
                                 : DvdBits'(dmt_pkg::LowModeNumerator);

   // Sequence each request through step and, if it needs division, load, divide, average (pulse-count mode) and emit
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      width_in   = width_ff;
      stale_in   = stale_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      ring_in    = ring_ff;
      ridx_in    = ridx_ff;
      speed_in   = speed_ff;
      cnt_lat_in = cnt_lat_ff;
      dvs_in     = dvs_ff;
      q_pop      = 1'b0;
      commit     = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_STEP: begin
            if (!q_empty) begin
               if (t_low_div || t_high_div) begin
                  q_pop      = 1'b1;
                  width_in   = t_w;
                  stale_in   = t_s;
                  window_in  = t_win;
                  count_in   = t_high_div ? '0 : t_cnt;
                  cnt_lat_in = t_cnt;
                  dvs_in     = t_high_div ? period : w_inc;
                  state_in   = ST_LOAD;
               end else if (out_free) begin
                  q_pop     = 1'b1;
                  commit    = 1'b1;
                  width_in  = t_w;
                  stale_in  = e_s;
                  window_in = e_win;
                  count_in  = e_cnt;
                  mode_in   = e_mode;
               end
            end
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (mode_ff) begin
                  ring_in[ridx_ff] = q_sat;
                  ridx_in          = ridx_ff + 1'b1;
                  state_in         = ST_SUM;
               end else begin
                  speed_in = q_sat;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SUM: begin
            speed_in = SpeedBits'(ring_sum >> dmt_pkg::RingIdxBits);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               commit    = 1'b1;
               stale_in  = e_s;
               window_in = e_win;
               count_in  = e_cnt;
               mode_in   = e_mode;
               state_in  = ST_STEP;
            end
         end
         default: begin
            state_in = ST_STEP;
         end
      endcase
   end

   // Output register: load on commit, drop once taken
   always_comb begin
      rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
      rsp_speed_in = commit ? e_out : rsp_speed_ff;
      rsp_mode_in  = commit ? e_mode : rsp_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_STEP;
         mode_ff      <= 1'b0;
         width_ff     <= '0;
         stale_ff     <= '0;
         window_ff    <= '0;
         count_ff     <= '0;
         ridx_ff      <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < dmt_pkg::RingDepth; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         width_ff     <= width_in;
         stale_ff     <= stale_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         ridx_ff      <= ridx_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_ff      <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_lat_ff   <= cnt_lat_in;
      dvs_ff       <= dvs_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

   dmt_div #(
      .DVD_BITS (DvdBits),
      .DVS_BITS (TIMER_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dvs_ff),
      .status   (div_stat),
      .quotient (div_quo)
   );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

   localparam int HalfPeriod    = 4;
   localparam int WatchdogLimit = 2000;
   localparam int HoldOffCycles = 200;
   localparam int DrainCycles   = 64;
   localparam int RandomPhases  = 12;
   localparam int PhaseTicks    = 125;
   localparam int ReportLimit   = 10;

   localparam int SpeedBits    = dmt_pkg::SpeedBits;
   localparam int CountBits    = dmt_pkg::CountBits;
   localparam int DebounceBits = dmt_pkg::DebounceBits;
   localparam int CutoffBits   = dmt_pkg::CutoffBits;
   localparam int CsrIndexBits = dmt_pkg::CsrIndexBits;
   localparam int CsrDataBits  = dmt_pkg::CsrDataBits;
   localparam int RingDepth    = dmt_pkg::RingDepth;
   localparam int RingIdxBits  = dmt_pkg::RingIdxBits;

   localparam logic [CsrIndexBits-1:0] CsrDebounce = dmt_pkg::CsrDebounce;
   localparam logic [CsrIndexBits-1:0] CsrCutoff   = dmt_pkg::CsrCutoff;
   localparam logic [CsrIndexBits-1:0] CsrStale    = dmt_pkg::CsrStale;
   localparam logic [CsrIndexBits-1:0] CsrPeriod   = dmt_pkg::CsrPeriod;

   localparam logic [CsrIndexBits-1:0] CsrUnmapped = '1;
   localparam logic [31:0]             TimerMax    = '1;
   localparam logic [SpeedBits-1:0]    SpeedMax    = '1;
   localparam logic [CountBits-1:0]    CountMax    = '1;
   localparam logic [DebounceBits-1:0] DebounceTop = 20'd1000000;
   localparam logic [31:0]             WidthScale  = 32'd15000000;
   localparam logic [63:0]             WindowScale = 64'd30000000;

   typedef struct packed {
      logic [SpeedBits-1:0] speed;
      logic                 high;
   } speed_report_type;

   // Tachometer predictor plus the queue of speed reports still owed
   class speed_scoreboard;
      logic [DebounceBits-1:0] debounce;
      logic [CutoffBits-1:0]   cutoff;
      logic [31:0]             stale_limit;
      logic [31:0]             window_len;
      logic                    high_mode;
      logic                    last_level;
      logic [31:0]             width_ticks;
      logic [31:0]             stale_ticks;
      logic [31:0]             window_ticks;
      logic [CountBits-1:0]    fall_tally;
      logic [SpeedBits-1:0]    ring [RingDepth];
      logic [RingIdxBits-1:0]  ring_ptr;
      logic [SpeedBits-1:0]    speed;
      speed_report_type        expected_q [$];
      int                      failures;

      function new();
         debounce     = dmt_pkg::DebounceReset;
         cutoff       = dmt_pkg::CutoffReset;
         stale_limit  = dmt_pkg::StaleReset;
         window_len   = dmt_pkg::PeriodReset;
         high_mode    = 1'b0;
         last_level   = 1'b0;
         width_ticks  = '0;
         stale_ticks  = '0;
         window_ticks = '0;
         fall_tally   = '0;
         foreach (ring[i]) ring[i] = '0;
         ring_ptr     = '0;
         speed        = '0;
         failures     = 0;
      endfunction

      function void set_reg(logic [CsrIndexBits-1:0] idx, logic [31:0] data);
         case (idx)
            CsrDebounce: debounce    = data[DebounceBits-1:0];
            CsrCutoff:   cutoff      = data[CutoffBits-1:0];
            CsrStale:    stale_limit = data;
            CsrPeriod:   window_len  = data;
            default: ;
         endcase
      endfunction

      function logic [31:0] bump(logic [31:0] t);
         return (t == TimerMax) ? t : t + 32'd1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advance one microsecond tick and queue the report it produces
      function void note_tick(logic level);
         logic                 rise;
         logic                 fall;
         logic [31:0]          period;
         logic [63:0]          entry;
         logic [63:0]          sum;
         logic [SpeedBits-1:0] shown;
         rise = level && !last_level;
         fall = !level && last_level;
         width_ticks = bump(width_ticks);
         stale_ticks = bump(stale_ticks);
         if (!high_mode) begin
            // pulse-width mode: time the high phase
            if (rise) width_ticks = '0;
            if (fall && width_ticks > debounce) begin
               speed       = SpeedBits'(WidthScale / width_ticks);
               stale_ticks = '0;
            end
         end else begin
            // pulse-count mode: count debounced falls, close windows into the ring
            period = (window_len == '0) ? 32'd1 : window_len;
            if (fall) begin
               if (width_ticks > debounce && fall_tally != CountMax)
                  fall_tally = fall_tally + 1'b1;
               width_ticks = '0;
            end
            window_ticks = bump(window_ticks);
            if (window_ticks >= period) begin
               entry = (64'(fall_tally) * WindowScale) / 64'(period);
               if (entry > 64'(SpeedMax)) entry = 64'(SpeedMax);
               ring[ring_ptr] = entry[SpeedBits-1:0];
               ring_ptr       = ring_ptr + 1'b1;
               fall_tally     = '0;
               window_ticks   = '0;
               sum = '0;
               foreach (ring[i]) sum += 64'(ring[i]);
               speed = SpeedBits'(sum >> 2);
            end
         end
         last_level = level;
         // re-evaluate the mode and form the output
         if (speed > cutoff) begin
            if (!high_mode) begin
               high_mode    = 1'b1;
               window_ticks = '0;
               fall_tally   = '0;
            end
            shown = speed;
         end else begin
            if (high_mode) begin
               high_mode   = 1'b0;
               stale_ticks = '0;
            end
            shown = (stale_ticks > stale_limit) ? '0 : speed;
         end
         expected_q.push_back('{shown, high_mode});
      endfunction

      // Compare one response with the oldest expected report
      function void check_report(speed_report_type got);
         speed_report_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= ReportLimit)
               $display("tb: response with no request pending: speed %0d high_mode %0b",
                        got.speed, got.high);
            return;
         end
         want = expected_q.pop_front();
         if (got.speed !== want.speed || got.high !== want.high) begin
            failures++;
            if (failures <= ReportLimit)
               $display({"tb: mismatch: expected speed %0d high_mode %0b, ",
                         "got speed %0d high_mode %0b"},
                        want.speed, want.high, got.speed, got.high);
         end
      endfunction
   endclass

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic                    req_tacho_level = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic [SpeedBits-1:0]    rsp_speed_value;
   logic                    rsp_high_mode;
   logic                    csr_valid       = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index       = '0;
   logic [CsrDataBits-1:0]  csr_wdata       = '0;

   bit idle_on     = 1'b1;
   bit hold_off_go = 1'b0;
   int quiet_cycles = 0;

   speed_scoreboard tach_sb = new();

   dual_mode_tachometer_core dut (.*);

   always #HalfPeriod clock = ~clock;

   // Stall responses at random; hold off for a long stretch on request
   always begin
      @(posedge clock);
      if (hold_off_go) begin
         hold_off_go = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HoldOffCycles) @(posedge clock);
      end
      rsp_stall <= idle_on && ($urandom_range(99) < 23);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tach_sb.check_report('{rsp_speed_value, rsp_high_mode});
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one tick request, idling first at random, and note it once accepted
   task automatic send_tick(input logic level);
      while (idle_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_tacho_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tach_sb.note_tick(level);
   endtask

   // Send levels from the most significant of count bits down
   task automatic send_pattern(input logic [31:0] levels, input int count);
      for (int i = count - 1; i >= 0; i--) send_tick(levels[i]);
   endtask

   // Drop valid and wait for every owed response
   task automatic settle();
      req_valid <= 1'b0;
      while (tach_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexBits-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tach_sb.set_reg(idx, data);
   endtask

   // Pick a register setting, mostly small values, sometimes the extremes
   task automatic pick_regs();
      logic [31:0] debounce;
      logic [31:0] cutoff;
      logic [31:0] stale;
      logic [31:0] period;
      case ($urandom_range(9))
         0:       debounce = 32'(DebounceTop);
         1:       debounce = 32'(DebounceTop | '1);
         default: debounce = $urandom_range(6);
      endcase
      case ($urandom_range(9))
         0:       cutoff = '0;
         1:       cutoff = 32'(SpeedMax);
         default: cutoff = $urandom_range(4000000, 100000);
      endcase
      case ($urandom_range(9))
         0:       stale = '0;
         1:       stale = TimerMax;
         default: stale = $urandom_range(80, 5);
      endcase
      case ($urandom_range(9))
         0:       period = '0;
         1:       period = TimerMax;
         2:       period = 32'd1;
         default: period = $urandom_range(48, 2);
      endcase
      write_reg(CsrDebounce, debounce);
      write_reg(CsrCutoff, cutoff);
      write_reg(CsrStale, stale);
      write_reg(CsrPeriod, period);
      if ($urandom_range(4) == 0)
         write_reg(CsrIndexBits'($urandom_range(CsrUnmapped, CsrPeriod + 1)), $urandom);
      csr_valid <= 1'b0;
   endtask

   // Random pin waveform: runs of random length, some one-tick glitches
   task automatic send_waveform(input int ticks, input int max_run);
      logic level;
      int   run;
      level = $urandom_range(1);
      while (ticks > 0) begin
         run   = ($urandom_range(99) < 15) ? 1 : $urandom_range(max_run, 1);
         level = ~level;
         for (int k = 0; k < run && ticks > 0; k++) begin
            send_tick(level);
            ticks--;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a pulse too short for the debounce limit
      send_pattern(32'b010, 3);
      settle();

      // pulse-width mode, every width accepted, speed goes stale at once
      write_reg(CsrDebounce, '0);
      write_reg(CsrCutoff, 32'(SpeedMax));
      write_reg(CsrStale, '0);
      write_reg(CsrPeriod, '0);
      csr_valid <= 1'b0;
      send_pattern(32'b100110, 6);
      settle();

      // zero cutoff: pulse-count mode, zero window acts as one tick, entries saturate
      write_reg(CsrCutoff, '0);
      csr_valid <= 1'b0;
      send_pattern(32'b101001, 6);
      settle();

      // top cutoff: back to pulse-width mode, first fall there has no rise before it
      write_reg(CsrCutoff, 32'(SpeedMax));
      write_reg(CsrStale, TimerMax);
      csr_valid <= 1'b0;
      send_pattern(32'b101110, 6);
      settle();

      // a large debounce, the window at its ceiling, and an unmapped register index
      write_reg(CsrDebounce, 32'(DebounceTop));
      write_reg(CsrPeriod, TimerMax);
      write_reg(CsrUnmapped, TimerMax);
      csr_valid <= 1'b0;
      send_pattern(32'b10, 2);
      settle();

      // random phases; one runs without idling and with a long response hold-off
      for (int phase = 0; phase < RandomPhases; phase++) begin
         pick_regs();
         idle_on = (phase != 3);
         if (phase == 3) hold_off_go = 1'b1;
         send_waveform(PhaseTicks, (phase % 3 == 2) ? 60 : 12);
         settle();
      end
      idle_on = 1'b1;

      // catch any stray responses
      repeat (DrainCycles) @(posedge clock);
      if (tach_sb.failures == 0 && tach_sb.pending() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
